FILE: rtl/bkhs_pkg.sv
// Package for the bottom-k hash sketch: action codes, constants and the
// word passed from the front end to the back end. No dependencies.
package bkhs_pkg;

    localparam int SKETCH_DEPTH_DEF  = 1024;
    localparam int SKETCH_SIZE_RESET = 1000;
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic [1:0] {
        ACT_OFFER = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [0:0] REG_SKETCH_SIZE = 1'd0;
    localparam logic [0:0] REG_WIDE_HASHES = 1'd1;

    typedef struct packed {
        t_action     action;
        logic [63:0] hash;
        logic [9:0]  index;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_SEARCH,
        ST_SHIFT,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/bkhs_ram.sv
// Generic RAM with one write port and one registered read port.
// No dependencies.
module bkhs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/bkhs_front.sv
// Front end: takes words, masks narrow hashes and queues commands.
// Depends on bkhs_pkg.
module bkhs_front import bkhs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_hash_value,
    input  logic [9:0]  i_read_index,
    input  logic        i_wide,
    output logic        o_cmd_valid,
    input  logic        i_cmd_take,
    output t_cmd        o_cmd
);
    t_cmd r_q [QUEUE_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;
    t_cmd in_cmd;

    always_comb begin
        in_cmd.action = t_action'(i_action);
        in_cmd.hash   = i_wide ? i_hash_value : {32'd0, i_hash_value[31:0]};
        in_cmd.index  = i_read_index;
    end

    assign o_stall     = (r_cnt == 2'(QUEUE_DEPTH));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

FILE: rtl/bkhs_back.sv
// Back end: sequencer that searches and shifts the sorted store in RAM.
// Depends on bkhs_pkg and bkhs_ram.
module bkhs_back import bkhs_pkg::*; #(
    parameter int SKETCH_DEPTH = SKETCH_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_take,
    input  t_cmd        i_cmd,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    output logic        o_wide,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accepted,
    output logic [63:0] o_entry_value,
    output logic        o_entry_valid,
    output logic [10:0] o_fill_count
);
    localparam int AW = $clog2(SKETCH_DEPTH);
    localparam int CW = AW + 1;
    localparam int CAP_RESET = (SKETCH_SIZE_RESET > SKETCH_DEPTH) ? SKETCH_DEPTH
                                                                  : SKETCH_SIZE_RESET;

    t_state r_state, n_state;
    logic [CW-1:0] r_held, r_cap;
    logic          r_wide;
    t_cmd          r_cmd;
    logic [CW-1:0] r_pos, r_i;
    logic          r_acc, r_evld, r_ovld;
    logic [63:0]   r_eval;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;
    logic [CW-1:0] cap_new;
    logic          full;
    logic          out_free;
    logic          take;

    bkhs_ram #(.WIDTH(64), .DEPTH(SKETCH_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign cap_new = (int'(i_cfg_data) > SKETCH_DEPTH) ? CW'(SKETCH_DEPTH)
                                                       : CW'(i_cfg_data);
    assign full = (r_held >= r_cap);
    assign o_wide = r_wide;

    // A new word is only taken once the result register is free or being read.
    assign out_free   = !r_ovld || !i_stall;
    assign take       = (r_state == ST_IDLE) && i_cmd_valid && out_free;
    assign o_cmd_take = take;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    unique case (i_cmd.action)
                        ACT_OFFER: n_state = ST_CHECK;
                        ACT_READ:  n_state = ST_READ;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_READ:   n_state = ST_DONE;
            ST_CHECK: begin
                // Read of the largest entry has landed; reject early if possible.
                if (r_cap == '0) n_state = ST_DONE;
                else if (full && !(r_cmd.hash < rdata)) n_state = ST_DONE;
                else n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (r_pos >= r_held || !(rdata < r_cmd.hash)) begin
                    if (r_pos < r_held && rdata == r_cmd.hash) n_state = ST_DONE;
                    else n_state = ST_SHIFT;
                end
            end
            ST_SHIFT:  if (r_i == r_pos) n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: RAM control.
    always_comb begin
        we = 1'b0;
        waddr = r_i[AW-1:0];
        wdata = rdata;
        raddr = r_pos[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                raddr = (i_cmd.action == ACT_READ) ? AW'(i_cmd.index)
                                                   : AW'(r_held - CW'(1));
            end
            ST_CHECK:  raddr = '0;
            ST_SEARCH: begin
                // When the search ends in a shift, the entry just below the
                // first slot to be written is read now, ready for the shift.
                if (n_state == ST_SHIFT) begin
                    raddr = full ? AW'(r_cap - CW'(2)) : AW'(r_held - CW'(1));
                end else begin
                    raddr = AW'(r_pos + CW'(1));
                end
            end
            ST_SHIFT: begin
                // Entry i-1 was read last cycle; it moves to i.
                we = 1'b1;
                if (r_i == r_pos) wdata = r_cmd.hash;
                raddr = AW'(r_i - CW'(2));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) r_cmd <= i_cmd;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held <= '0;
            r_cap <= CW'(CAP_RESET);
            r_wide <= 1'b1;
            r_ovld <= 1'b0;
            r_acc <= 1'b0;
            r_evld <= 1'b0;
            r_eval <= '0;
            r_pos <= '0;
            r_i <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE) r_ovld <= 1'b1;
            else if (o_valid && !i_stall) r_ovld <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SKETCH_SIZE) begin
                    r_cap <= cap_new;
                    if (r_held > cap_new) r_held <= cap_new;
                end else if (i_cfg_index == REG_WIDE_HASHES) begin
                    if (i_cfg_data[0] != r_wide) r_held <= '0;
                    r_wide <= i_cfg_data[0];
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        r_acc <= 1'b0;
                        r_evld <= 1'b0;
                        r_eval <= '0;
                        r_pos <= '0;
                        if (i_cmd.action == ACT_CLEAR) r_held <= '0;
                    end
                end
                ST_READ: begin
                    if (int'(r_cmd.index) < int'(r_held)) begin
                        r_evld <= 1'b1;
                        r_eval <= rdata;
                    end
                end
                ST_SEARCH: begin
                    if (n_state == ST_SHIFT) begin
                        // Full sketch drops its largest entry before the shift.
                        if (full) begin
                            r_i <= r_cap - CW'(1);
                            r_held <= r_cap;
                        end else begin
                            r_i <= r_held;
                            r_held <= r_held + CW'(1);
                        end
                        r_acc <= 1'b1;
                    end else if (n_state == ST_SEARCH) begin
                        r_pos <= r_pos + CW'(1);
                    end
                end
                ST_SHIFT: begin
                    r_i <= r_i - CW'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_ovld;
    assign o_accepted    = r_acc;
    assign o_entry_value = r_eval;
    assign o_entry_valid = r_evld;
    assign o_fill_count  = 11'(r_held);
endmodule

FILE: rtl/bottom_k_hash_sketch.sv
// Top level of the bottom-k hash sketch: front queue and back sequencer.
// Depends on bkhs_pkg, bkhs_front, bkhs_back and bkhs_ram.
//
//   channel | direction | handshake
//   input   | in        | i_valid / o_stall
//   output  | out       | o_valid / i_stall
//   config  | in        | i_cfg_we, no wait
//
// From input acceptance to a valid result, a clear or unused action passes
// IDLE and DONE, a read IDLE, READ and DONE, and an offer IDLE and CHECK,
// then DONE if the largest-entry compare rejects it, else SEARCH, then DONE
// for a duplicate or SHIFT and DONE for an insertion. The front queue holds
// two words; the back end takes no new word while a result waits on a
// stalled output. Reset is synchronous and empties the sketch at once.
module bottom_k_hash_sketch import bkhs_pkg::*; #(
    parameter int SKETCH_DEPTH = SKETCH_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_hash_value,
    input  logic [9:0]  i_read_index,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_accepted,
    output logic [63:0] o_entry_value,
    output logic        o_entry_valid,
    output logic [10:0] o_fill_count
);
    t_cmd cmd;
    logic cmd_valid, cmd_take, wide;

    bkhs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_hash_value(i_hash_value),
        .i_read_index(i_read_index), .i_wide(wide),
        .o_cmd_valid(cmd_valid), .i_cmd_take(cmd_take), .o_cmd(cmd)
    );

    bkhs_back #(.SKETCH_DEPTH(SKETCH_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid),
        .o_cmd_take(cmd_take), .i_cmd(cmd), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_wide(wide),
        .o_valid(o_valid), .i_stall(i_stall), .o_accepted(o_accepted),
        .o_entry_value(o_entry_value), .o_entry_valid(o_entry_valid),
        .o_fill_count(o_fill_count)
    );
endmodule

FILE: rtl/bkhs_checker.sv
// Port-level checker for the bottom-k hash sketch, bound to the top level.
// Depends on bottom_k_hash_sketch.
module bkhs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_accepted,
    input logic [63:0] o_entry_value,
    input logic        o_entry_valid,
    input logic [10:0] o_fill_count
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_fill_count))
        else $error("stalled word changed");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_accepted && o_entry_valid))
        else $error("accept and read in one word");
    a_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_entry_valid |-> o_entry_value == 64'd0)
        else $error("invalid read carries data");
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> o_fill_count != 11'd0)
        else $error("accepted into empty sketch");
endmodule

bind bottom_k_hash_sketch bkhs_checker u_chk (.*);

FILE: dv/bottom_k_hash_sketch_test.sv
// Self-checking testbench for the bottom-k hash sketch: drives random and directed words,
// predicts each result from a sorted model of the sketch and compares them field by field.
// Depends on bkhs_pkg and bottom_k_hash_sketch.
`timescale 1ns / 1ps

module bottom_k_hash_sketch_test;
    import bkhs_pkg::*;

    localparam int DEPTH = 1024;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        t_action     action;
        logic [63:0] hash;
        logic [9:0]  index;
    } t_word;

    typedef struct packed {
        logic        accepted;
        logic [63:0] value;
        logic        valid;
        logic [10:0] fill;
    } t_result;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [1:0]  i_action = '0;
    logic [63:0] i_hash_value = '0;
    logic [9:0]  i_read_index = '0;
    logic        i_cfg_we = 0;
    logic [0:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic        o_accepted;
    logic [63:0] o_entry_value;
    logic        o_entry_valid;
    logic [10:0] o_fill_count;

    bottom_k_hash_sketch dut (.*);

    // Predictor state: sorted entries, fill count and configuration.
    logic [63:0] sorted_hashes [DEPTH];
    int          held;
    int          size_reg;
    logic        wide_reg;

    t_word   pending_words [$];
    t_result expected_results [$];
    int      mismatches;
    int      words_sent;
    int      results_seen;
    int      accepts_seen;
    int      idle_cycles;
    int      send_gap;
    int      stall_left;
    logic    hold_off;
    logic    taken_last = 0;
    t_word   in_flight;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int capacity_now();
        return (size_reg > DEPTH) ? DEPTH : size_reg;
    endfunction

    function automatic t_result predict_result(t_word w);
        t_result     r;
        logic [63:0] h;
        int          cap;
        int          pos;
        r = '0;
        h = wide_reg ? w.hash : {32'd0, w.hash[31:0]};
        cap = capacity_now();
        case (w.action)
            ACT_OFFER: begin
                if (cap != 0 && !(held >= cap && !(h < sorted_hashes[held-1]))) begin
                    pos = 0;
                    while (pos < held && sorted_hashes[pos] < h) pos++;
                    if (!(pos < held && sorted_hashes[pos] == h)) begin
                        if (held >= cap) held = cap - 1;
                        for (int i = held; i > pos; i--) sorted_hashes[i] = sorted_hashes[i-1];
                        sorted_hashes[pos] = h;
                        held++;
                        r.accepted = 1;
                    end
                end
            end
            ACT_READ: begin
                if (w.index < held) begin
                    r.value = sorted_hashes[w.index];
                    r.valid = 1;
                end
            end
            ACT_CLEAR: held = 0;
            default: ;
        endcase
        r.fill = held[10:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Driver: presents queued words, holding each until it is taken, and stalls the output at random.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || taken_last) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 0;
                end else if (!hold_off && pending_words.size() > 0) begin
                    i_action <= pending_words[0].action;
                    i_hash_value <= pending_words[0].hash;
                    i_read_index <= pending_words[0].index;
                    pending_words.delete(0);
                    i_valid <= 1;
                    send_gap <= pick_gap();
                end else begin
                    i_valid <= 0;
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1;
            end else begin
                i_stall <= 0;
                stall_left <= pick_gap();
            end
        end
    end

    // Monitor: predicts on input acceptance and checks on output acceptance.
    always @(posedge i_clk) begin
        t_result want;
        t_result pred;
        logic    busy;
        busy = 1'b0;
        taken_last <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                in_flight.action = t_action'(i_action);
                in_flight.hash = i_hash_value;
                in_flight.index = i_read_index;
                pred = predict_result(in_flight);
                expected_results.insert(expected_results.size(), pred);
                words_sent <= words_sent + 1;
                busy = 1'b1;
            end
            if (o_valid && !i_stall) begin
                busy = 1'b1;
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(o_fill_count), 64'd0);
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (o_accepted) accepts_seen <= accepts_seen + 1;
                    if (o_accepted !== want.accepted)
                        report_mismatch("accepted", 64'(o_accepted), 64'(want.accepted));
                    if (o_entry_value !== want.value)
                        report_mismatch("entry_value", o_entry_value, want.value);
                    if (o_entry_valid !== want.valid)
                        report_mismatch("entry_valid", 64'(o_entry_valid), 64'(want.valid));
                    if (o_fill_count !== want.fill)
                        report_mismatch("fill_count", 64'(o_fill_count), 64'(want.fill));
                end
            end
            idle_cycles <= busy ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles with no acceptance on either channel.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired");
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_word(t_action a, logic [63:0] h, logic [9:0] idx);
        t_word w;
        w.action = a;
        w.hash = h;
        w.index = idx;
        pending_words.insert(pending_words.size(), w);
    endtask

    // Waits until the block has drained all queued and expected words.
    task automatic wait_drained();
        while (pending_words.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_register(logic [0:0] idx, logic [10:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == REG_SKETCH_SIZE) begin
            size_reg = int'(value);
            if (held > capacity_now()) held = capacity_now();
        end else begin
            if (value[0] != wide_reg) held = 0;
            wide_reg = value[0];
        end
    endtask

    function automatic logic [63:0] random_hash(logic small_range);
        logic [63:0] h;
        h = {$urandom, $urandom};
        if (small_range) h = 64'($urandom_range(0, 300));
        return h;
    endfunction

    // One phase of random words: mostly offers and reads, some clears and unused actions.
    task automatic random_phase(int count, int max_read);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                queue_word(ACT_OFFER, random_hash($urandom_range(0, 2) == 0), '0);
            else if (roll < 92)
                queue_word(ACT_READ, {$urandom, $urandom},
                           10'($urandom_range(0, max_read)));
            else if (roll < 96)
                queue_word(ACT_CLEAR, {$urandom, $urandom}, 10'($urandom));
            else
                queue_word(ACT_NONE, {$urandom, $urandom}, 10'($urandom));
        end
    endtask

    initial begin
        mismatches = 0;
        words_sent = 0;
        results_seen = 0;
        accepts_seen = 0;
        idle_cycles = 0;
        send_gap = 0;
        stall_left = 0;
        hold_off = 0;
        held = 0;
        size_reg = 1000;
        wide_reg = 1;
        for (int i = 0; i < DEPTH; i++) sorted_hashes[i] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, every action, equal and duplicate hashes, invalid reads.
        write_register(REG_SKETCH_SIZE, 11'd3);
        queue_word(ACT_READ, '0, 10'd0);
        queue_word(ACT_OFFER, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        queue_word(ACT_OFFER, 64'd0, '0);
        queue_word(ACT_OFFER, 64'd0, '0);
        queue_word(ACT_OFFER, 64'h8000_0000_0000_0000, '0);
        queue_word(ACT_OFFER, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        queue_word(ACT_OFFER, 64'h0000_0001_0000_0000, '0);
        queue_word(ACT_READ, '0, 10'd0);
        queue_word(ACT_READ, '0, 10'd1);
        queue_word(ACT_READ, '0, 10'd2);
        queue_word(ACT_READ, '1, 10'd1023);
        queue_word(ACT_NONE, '1, 10'd1023);
        queue_word(ACT_CLEAR, '1, '1);
        queue_word(ACT_READ, '0, 10'd0);
        wait_drained();
        write_register(REG_WIDE_HASHES, 1'b0);
        queue_word(ACT_OFFER, 64'hFFFF_FFFF_0000_0005, '0);
        queue_word(ACT_OFFER, 64'h0000_0000_0000_0005, '0);
        queue_word(ACT_OFFER, 64'h1234_5678_FFFF_FFFF, '0);
        queue_word(ACT_READ, '0, 10'd1);
        wait_drained();
        write_register(REG_WIDE_HASHES, 1'b0);
        write_register(REG_SKETCH_SIZE, 11'd0);
        queue_word(ACT_OFFER, 64'd7, '0);
        queue_word(ACT_READ, '0, 10'd0);
        wait_drained();

        // Random phases over several settings, extremes included.
        write_register(REG_SKETCH_SIZE, 11'd8);
        random_phase(150, 12);
        wait_drained();
        write_register(REG_SKETCH_SIZE, 11'd1);
        random_phase(100, 3);
        wait_drained();
        write_register(REG_WIDE_HASHES, 1'b1);
        write_register(REG_SKETCH_SIZE, 11'd2047);
        random_phase(250, 300);
        wait_drained();
        write_register(REG_SKETCH_SIZE, 11'd5);

        // Part way through, hold back the sender until every expected result has come.
        random_phase(100, 8);
        repeat (40) @(posedge i_clk);
        hold_off = 1;
        while (expected_results.size() > 0 || i_valid) @(posedge i_clk);
        hold_off = 0;
        wait_drained();
        write_register(REG_SKETCH_SIZE, 11'd1024);
        write_register(REG_WIDE_HASHES, 1'b0);
        random_phase(200, 200);
        wait_drained();
        write_register(REG_SKETCH_SIZE, 11'd16);
        random_phase(230, 24);
        wait_drained();

        $display("Sent %0d words and checked %0d results, %0d offers accepted,",
                 words_sent, results_seen, accepts_seen);
        $display("over sizes 0 to 2047 in both hash widths.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
